// ===== rtl/spmf_pkg.sv =====
// Shared constants for the support point mask filter: table sizes, widths,
// opcodes and status codes. Used by every module in rtl/ except spmf_ram.
package spmf_pkg;

    localparam int MAX_LAYERS   = 64;
    localparam int MAX_POLYGONS = 256;
    localparam int MAX_VERTICES = 4096;
    localparam int COORD_BITS   = 32;

    localparam int OBJ_W   = 8;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    localparam int LAYER_AW = $clog2(MAX_LAYERS);
    localparam int LAYER_CW = $clog2(MAX_LAYERS + 1);
    localparam int POLY_AW  = $clog2(MAX_POLYGONS);
    localparam int POLY_CW  = $clog2(MAX_POLYGONS + 1);
    localparam int VERT_AW  = $clog2(MAX_VERTICES);
    localparam int VERT_CW  = $clog2(MAX_VERTICES + 1);

    localparam int DIFF_W = COORD_BITS + 1;
    localparam int PROD_W = 2 * DIFF_W;

    // Layer entry: object id, height, index of its first polygon.
    localparam int LAYER_W = OBJ_W + COORD_BITS + POLY_CW;
    // Polygon entry: kind, index of its first vertex.
    localparam int POLY_W  = 1 + VERT_CW;
    // Vertex entry: x, y.
    localparam int VERT_W  = 2 * COORD_BITS;

    localparam logic [OP_W-1:0] OP_CLEAR   = 3'd0;
    localparam logic [OP_W-1:0] OP_LAYER   = 3'd1;
    localparam logic [OP_W-1:0] OP_POLYGON = 3'd2;
    localparam logic [OP_W-1:0] OP_VERTEX  = 3'd3;
    localparam logic [OP_W-1:0] OP_QUERY   = 3'd4;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STAT_W-1:0] ST_NOOPEN = 2'd2;

    typedef logic signed [COORD_BITS-1:0] coord_t;

endpackage

// ===== rtl/spmf_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module spmf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/spmf_cross.sv =====
// Edge crossing test for even-odd ray casting, done exactly with one shared
// signed multiplier used twice and a final compare. Depends on spmf_pkg.
module spmf_cross (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            start,
    input  spmf_pkg::coord_t ax,
    input  spmf_pkg::coord_t ay,
    input  spmf_pkg::coord_t bx,
    input  spmf_pkg::coord_t by,
    input  spmf_pkg::coord_t px,
    input  spmf_pkg::coord_t py,
    output logic            done,
    output logic            toggle
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL1 = 2'd1;
    localparam logic [1:0] S_MUL2 = 2'd2;
    localparam logic [1:0] S_CMP  = 2'd3;

    logic [1:0] step_reg, step_next;
    logic signed [spmf_pkg::DIFF_W-1:0] dx1_reg, dy_reg, dx2_reg, dy2_reg;
    logic signed [spmf_pkg::PROD_W-1:0] p1_reg, p2_reg, prod;
    logic signed [spmf_pkg::DIFF_W-1:0] mul_a, mul_b;
    logic straddle_reg, dypos_reg;

    always_comb
    begin
        mul_a = (step_reg == S_MUL1) ? dx1_reg : dx2_reg;
        mul_b = (step_reg == S_MUL1) ? dy_reg : dy2_reg;
        prod  = mul_a * mul_b;
    end

    always_comb
    begin
        case (step_reg)
            S_IDLE:  step_next = start ? S_MUL1 : S_IDLE;
            S_MUL1:  step_next = S_MUL2;
            S_MUL2:  step_next = S_CMP;
            S_CMP:   step_next = S_IDLE;
            default: step_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= S_IDLE;
        end
        else
        begin
            step_reg <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step_reg == S_IDLE && start)
        begin
            dx1_reg      <= spmf_pkg::DIFF_W'(px) - spmf_pkg::DIFF_W'(ax);
            dy_reg       <= spmf_pkg::DIFF_W'(by) - spmf_pkg::DIFF_W'(ay);
            dx2_reg      <= spmf_pkg::DIFF_W'(bx) - spmf_pkg::DIFF_W'(ax);
            dy2_reg      <= spmf_pkg::DIFF_W'(py) - spmf_pkg::DIFF_W'(ay);
            straddle_reg <= (ay > py) != (by > py);
            dypos_reg    <= by > ay;
        end
        if (step_reg == S_MUL1)
        begin
            p1_reg <= prod;
        end
        if (step_reg == S_MUL2)
        begin
            p2_reg <= prod;
        end
    end

    // The sense of the compare flips when the edge runs downward.
    assign done   = (step_reg == S_CMP);
    assign toggle = straddle_reg && (dypos_reg ? (p1_reg < p2_reg) : (p1_reg > p2_reg));

endmodule

// ===== rtl/support_point_mask_filter_top.sv =====
// Top level of the support point mask filter: load/query sequencer and the
// layer, polygon and vertex memories. Depends on spmf_pkg, spmf_ram, spmf_cross.
//
// Clear, add layer, add polygon and add vertex items are done in the idle state
// as they are accepted. A query scans the layer table with a read and a check
// per loaded layer. For each polygon of the chosen layer it then fetches the
// polygon's vertex range and the closing vertex and checks the next polygon,
// and for each vertex it does one vertex read plus the crossing unit's three
// steps. The single vertex memory read port and the shared multiplier set how
// long a query takes. One item is in work at a time; a new item is taken once
// the previous result has been delivered.
module support_point_mask_filter_top (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  logic                         cfg_data,
    input  logic                         in_valid,
    output logic                         in_ready,
    input  logic [spmf_pkg::OP_W-1:0]    opcode,
    input  logic [spmf_pkg::OBJ_W-1:0]   object_number,
    input  spmf_pkg::coord_t             coord_x,
    input  spmf_pkg::coord_t             coord_y,
    input  spmf_pkg::coord_t             coord_z,
    input  logic                         mask_kind,
    output logic                         out_valid,
    input  logic                         out_ready,
    output logic [spmf_pkg::STAT_W-1:0]  status,
    output logic                         keep_point,
    output logic                         layer_found,
    output logic                         inside_enforcer,
    output logic                         inside_blocker
);

    localparam int LAW = spmf_pkg::LAYER_AW;
    localparam int LCW = spmf_pkg::LAYER_CW;
    localparam int PAW = spmf_pkg::POLY_AW;
    localparam int PCW = spmf_pkg::POLY_CW;
    localparam int VAW = spmf_pkg::VERT_AW;
    localparam int VCW = spmf_pkg::VERT_CW;
    localparam int CB  = spmf_pkg::COORD_BITS;
    localparam int OW  = spmf_pkg::OBJ_W;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_LREQ   = 4'd1;
    localparam logic [3:0] S_LCHK   = 4'd2;
    localparam logic [3:0] S_PCHK   = 4'd3;
    localparam logic [3:0] S_PREQ0  = 4'd4;
    localparam logic [3:0] S_PRD0   = 4'd5;
    localparam logic [3:0] S_PREQ1  = 4'd6;
    localparam logic [3:0] S_PRD1   = 4'd7;
    localparam logic [3:0] S_VSTART = 4'd8;
    localparam logic [3:0] S_VREQP  = 4'd9;
    localparam logic [3:0] S_VRDP   = 4'd10;
    localparam logic [3:0] S_VREQ   = 4'd11;
    localparam logic [3:0] S_VRD    = 4'd12;
    localparam logic [3:0] S_VWAIT  = 4'd13;
    localparam logic [3:0] S_PDONE  = 4'd14;
    localparam logic [3:0] S_FINISH = 4'd15;

    logic [3:0] state_reg;
    logic       enf_only_reg;
    logic [LCW-1:0] layer_total_reg;
    logic [PCW-1:0] poly_total_reg;
    logic [VCW-1:0] vert_total_reg;

    logic out_valid_reg;
    logic [spmf_pkg::STAT_W-1:0] status_reg;
    logic keep_reg, found_reg, enf_reg, blk_reg;

    // Query working registers
    logic [OW-1:0]    q_obj_reg;
    spmf_pkg::coord_t q_x_reg, q_y_reg, q_z_reg;
    logic [LCW-1:0]   li_reg;
    logic             have_reg, prev_hit_reg;
    spmf_pkg::coord_t best_reg;
    logic [PCW-1:0]   pend_reg, p_reg;
    logic             kind_reg;
    logic [VCW-1:0]   vfirst_reg, vend_reg, vi_reg;
    logic             inside_reg;
    spmf_pkg::coord_t ax_reg, ay_reg, bx_reg, by_reg;

    logic accept;
    assign accept = in_valid && in_ready;

    // Memories
    logic                          l_we, p_we, v_we;
    logic [spmf_pkg::LAYER_W-1:0]  l_wdata, l_rdata;
    logic [spmf_pkg::POLY_W-1:0]   p_wdata, p_rdata;
    logic [spmf_pkg::VERT_W-1:0]   v_wdata, v_rdata;
    logic [PAW-1:0]                p_raddr;
    logic [VAW-1:0]                v_raddr;
    logic [PCW-1:0]                p_next_idx;
    logic [VCW-1:0]                v_last;

    assign l_we = accept && opcode == spmf_pkg::OP_LAYER
               && layer_total_reg < LCW'(spmf_pkg::MAX_LAYERS);
    assign p_we = accept && opcode == spmf_pkg::OP_POLYGON && layer_total_reg != '0
               && poly_total_reg < PCW'(spmf_pkg::MAX_POLYGONS);
    assign v_we = accept && opcode == spmf_pkg::OP_VERTEX && poly_total_reg != '0
               && vert_total_reg < VCW'(spmf_pkg::MAX_VERTICES);

    assign l_wdata = {object_number, coord_z, poly_total_reg};
    assign p_wdata = {mask_kind, vert_total_reg};
    assign v_wdata = {coord_x, coord_y};

    assign p_next_idx = p_reg + PCW'(1);
    assign v_last     = vend_reg - VCW'(1);
    assign p_raddr    = (state_reg == S_PREQ1) ? p_next_idx[PAW-1:0] : p_reg[PAW-1:0];
    assign v_raddr    = (state_reg == S_VREQP) ? v_last[VAW-1:0] : vi_reg[VAW-1:0];

    spmf_ram #(.WIDTH(spmf_pkg::LAYER_W), .DEPTH(spmf_pkg::MAX_LAYERS)) u_layer_ram (
        .clk   (clk),
        .we    (l_we),
        .waddr (layer_total_reg[LAW-1:0]),
        .wdata (l_wdata),
        .raddr (li_reg[LAW-1:0]),
        .rdata (l_rdata)
    );

    spmf_ram #(.WIDTH(spmf_pkg::POLY_W), .DEPTH(spmf_pkg::MAX_POLYGONS)) u_poly_ram (
        .clk   (clk),
        .we    (p_we),
        .waddr (poly_total_reg[PAW-1:0]),
        .wdata (p_wdata),
        .raddr (p_raddr),
        .rdata (p_rdata)
    );

    spmf_ram #(.WIDTH(spmf_pkg::VERT_W), .DEPTH(spmf_pkg::MAX_VERTICES)) u_vert_ram (
        .clk   (clk),
        .we    (v_we),
        .waddr (vert_total_reg[VAW-1:0]),
        .wdata (v_wdata),
        .raddr (v_raddr),
        .rdata (v_rdata)
    );

    // Layer entry fields
    logic [OW-1:0]    l_obj;
    spmf_pkg::coord_t l_h;
    logic [PCW-1:0]   l_fp;
    logic             l_match;
    assign l_obj = l_rdata[spmf_pkg::LAYER_W-1 -: OW];
    assign l_h   = l_rdata[PCW +: CB];
    assign l_fp  = l_rdata[PCW-1:0];
    assign l_match = (l_obj == q_obj_reg) && (l_h >= q_z_reg) && (!have_reg || l_h < best_reg);

    // The current vertex is fed straight from the read port so the crossing
    // unit sees it in the same cycle it is started.
    spmf_pkg::coord_t va_x, va_y;
    assign va_x = v_rdata[spmf_pkg::VERT_W-1 -: CB];
    assign va_y = v_rdata[CB-1:0];

    logic cross_start, cross_done, cross_toggle;
    assign cross_start = (state_reg == S_VRD);

    spmf_cross u_cross (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cross_start),
        .ax     (va_x),
        .ay     (va_y),
        .bx     (bx_reg),
        .by     (by_reg),
        .px     (q_x_reg),
        .py     (q_y_reg),
        .done   (cross_done),
        .toggle (cross_toggle)
    );

    assign cfg_ready = 1'b1;
    assign in_ready  = (state_reg == S_IDLE) && !out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            enf_only_reg    <= 1'b0;
            layer_total_reg <= '0;
            poly_total_reg  <= '0;
            vert_total_reg  <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                enf_only_reg <= cfg_data;
            end
            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        if (opcode == spmf_pkg::OP_QUERY)
                        begin
                            state_reg <= (layer_total_reg == '0) ? S_FINISH : S_LREQ;
                        end
                        else
                        begin
                            out_valid_reg <= 1'b1;
                        end
                        if (opcode == spmf_pkg::OP_CLEAR)
                        begin
                            layer_total_reg <= '0;
                            poly_total_reg  <= '0;
                            vert_total_reg  <= '0;
                        end
                        if (l_we)
                        begin
                            layer_total_reg <= layer_total_reg + LCW'(1);
                        end
                        if (p_we)
                        begin
                            poly_total_reg <= poly_total_reg + PCW'(1);
                        end
                        if (v_we)
                        begin
                            vert_total_reg <= vert_total_reg + VCW'(1);
                        end
                    end
                end
                S_LREQ:  state_reg <= S_LCHK;
                S_LCHK:
                begin
                    if (li_reg + LCW'(1) == layer_total_reg)
                    begin
                        state_reg <= (have_reg || l_match) ? S_PCHK : S_FINISH;
                    end
                    else
                    begin
                        state_reg <= S_LREQ;
                    end
                end
                S_PCHK:
                begin
                    state_reg <= (p_reg < pend_reg && p_reg < poly_total_reg) ? S_PREQ0
                                                                              : S_FINISH;
                end
                S_PREQ0: state_reg <= S_PRD0;
                S_PRD0:  state_reg <= (p_next_idx < poly_total_reg) ? S_PREQ1 : S_VSTART;
                S_PREQ1: state_reg <= S_PRD1;
                S_PRD1:  state_reg <= S_VSTART;
                S_VSTART: state_reg <= (vend_reg <= vfirst_reg) ? S_PDONE : S_VREQP;
                S_VREQP: state_reg <= S_VRDP;
                S_VRDP:  state_reg <= S_VREQ;
                S_VREQ:  state_reg <= S_VRD;
                S_VRD:   state_reg <= S_VWAIT;
                S_VWAIT:
                begin
                    if (cross_done)
                    begin
                        state_reg <= (vi_reg + VCW'(1) == vend_reg) ? S_PDONE : S_VREQ;
                    end
                end
                S_PDONE: state_reg <= S_PCHK;
                S_FINISH:
                begin
                    out_valid_reg <= 1'b1;
                    state_reg     <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    q_obj_reg    <= object_number;
                    q_x_reg      <= coord_x;
                    q_y_reg      <= coord_y;
                    q_z_reg      <= coord_z;
                    li_reg       <= '0;
                    have_reg     <= 1'b0;
                    prev_hit_reg <= 1'b0;
                    keep_reg     <= 1'b0;
                    found_reg    <= 1'b0;
                    enf_reg      <= 1'b0;
                    blk_reg      <= 1'b0;
                    if (opcode == spmf_pkg::OP_LAYER && !l_we)
                    begin
                        status_reg <= spmf_pkg::ST_FULL;
                    end
                    else if (opcode == spmf_pkg::OP_POLYGON && !p_we)
                    begin
                        status_reg <= (layer_total_reg == '0) ? spmf_pkg::ST_NOOPEN
                                                              : spmf_pkg::ST_FULL;
                    end
                    else if (opcode == spmf_pkg::OP_VERTEX && !v_we)
                    begin
                        status_reg <= (poly_total_reg == '0) ? spmf_pkg::ST_NOOPEN
                                                             : spmf_pkg::ST_FULL;
                    end
                    else
                    begin
                        status_reg <= spmf_pkg::ST_OK;
                    end
                end
            end
            S_LCHK:
            begin
                // The end of the chosen layer's polygon run is the next layer's
                // first polygon, or the polygon total for the last layer.
                if (l_match)
                begin
                    have_reg   <= 1'b1;
                    best_reg   <= l_h;
                    p_reg      <= l_fp;
                    pend_reg   <= poly_total_reg;
                end
                else if (prev_hit_reg)
                begin
                    pend_reg <= l_fp;
                end
                prev_hit_reg <= l_match;
                li_reg       <= li_reg + LCW'(1);
            end
            S_PRD0:
            begin
                kind_reg   <= p_rdata[spmf_pkg::POLY_W-1];
                vfirst_reg <= p_rdata[VCW-1:0];
                vend_reg   <= vert_total_reg;
            end
            S_PRD1:  vend_reg <= p_rdata[VCW-1:0];
            S_VSTART:
            begin
                inside_reg <= 1'b0;
                vi_reg     <= vfirst_reg;
            end
            S_VRDP:
            begin
                bx_reg <= v_rdata[spmf_pkg::VERT_W-1 -: CB];
                by_reg <= v_rdata[CB-1:0];
            end
            S_VRD:
            begin
                ax_reg <= va_x;
                ay_reg <= va_y;
            end
            S_VWAIT:
            begin
                if (cross_done)
                begin
                    if (cross_toggle)
                    begin
                        inside_reg <= !inside_reg;
                    end
                    bx_reg <= ax_reg;
                    by_reg <= ay_reg;
                    vi_reg <= vi_reg + VCW'(1);
                end
            end
            S_PDONE:
            begin
                if (inside_reg)
                begin
                    if (kind_reg)
                    begin
                        enf_reg <= 1'b1;
                    end
                    else
                    begin
                        blk_reg <= 1'b1;
                    end
                end
                p_reg <= p_next_idx;
            end
            S_FINISH:
            begin
                found_reg <= have_reg;
                keep_reg  <= have_reg && (enf_reg || (!enf_only_reg && !blk_reg));
            end
            default:
            begin
            end
        endcase
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign keep_point      = keep_reg;
    assign layer_found     = found_reg;
    assign inside_enforcer = enf_reg;
    assign inside_blocker  = blk_reg;

endmodule

// ===== tb/sv/support_point_mask_filter_top_tb.sv =====
// Self-checking testbench for support_point_mask_filter_top: loads mask tables,
// queries points and compares every result against a built-in predictor.
// Depends on spmf_pkg and the RTL in rtl/.
module support_point_mask_filter_top_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import spmf_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic keep;
        logic found;
        logic enf;
        logic blk;
    } filter_result_t;

    // Predicts filter results and holds the ones still in flight.
    class mask_filter_scoreboard;
        bit enf_only;
        int n_layers, n_polys, n_verts;
        logic [7:0] lay_obj [MAX_LAYERS];
        longint lay_z [MAX_LAYERS];
        int lay_poly [MAX_LAYERS];
        bit poly_enf [MAX_POLYGONS];
        int poly_vert [MAX_POLYGONS];
        longint vx [MAX_VERTICES];
        longint vy [MAX_VERTICES];
        filter_result_t pending [$];
        int mismatches;
        int results_seen;

        function bit ray_inside(int first, int last, longint px, longint py);
            bit odd;
            int prev;
            longint dy;
            logic signed [127:0] lhs, rhs;
            odd = 0;
            if (last <= first) return 0;
            prev = last - 1;
            for (int i = first; i < last; i++) begin
                if ((vy[i] > py) != (vy[prev] > py)) begin
                    dy = vy[prev] - vy[i];
                    lhs = 128'(px - vx[i]) * 128'(dy);
                    rhs = 128'(vx[prev] - vx[i]) * 128'(py - vy[i]);
                    if (dy > 0 ? lhs < rhs : lhs > rhs) odd = !odd;
                end
                prev = i;
            end
            return odd;
        endfunction

        function void note_item(logic [2:0] op, logic [7:0] obj, longint x, longint y,
                                longint z, bit kind);
            filter_result_t r;
            int sel, pend, vend;
            r = '0;
            case (op)
                OP_CLEAR: begin
                    n_layers = 0; n_polys = 0; n_verts = 0;
                end
                OP_LAYER:
                    if (n_layers >= MAX_LAYERS) r.status = ST_FULL;
                    else begin
                        lay_obj[n_layers] = obj; lay_z[n_layers] = z;
                        lay_poly[n_layers] = n_polys; n_layers++;
                    end
                OP_POLYGON:
                    if (n_layers == 0) r.status = ST_NOOPEN;
                    else if (n_polys >= MAX_POLYGONS) r.status = ST_FULL;
                    else begin
                        poly_enf[n_polys] = kind; poly_vert[n_polys] = n_verts; n_polys++;
                    end
                OP_VERTEX:
                    if (n_polys == 0) r.status = ST_NOOPEN;
                    else if (n_verts >= MAX_VERTICES) r.status = ST_FULL;
                    else begin
                        vx[n_verts] = x; vy[n_verts] = y; n_verts++;
                    end
                OP_QUERY: begin
                    sel = -1;
                    for (int l = 0; l < n_layers; l++)
                        if (lay_obj[l] == obj && lay_z[l] >= z &&
                            (sel < 0 || lay_z[l] < lay_z[sel])) sel = l;
                    if (sel >= 0) begin
                        pend = (sel + 1 < n_layers) ? lay_poly[sel+1] : n_polys;
                        for (int p = lay_poly[sel]; p < pend && p < n_polys; p++) begin
                            vend = (p + 1 < n_polys) ? poly_vert[p+1] : n_verts;
                            if (ray_inside(poly_vert[p], vend, x, y)) begin
                                if (poly_enf[p]) r.enf = 1;
                                else r.blk = 1;
                            end
                        end
                        r.found = 1;
                        r.keep = r.enf || (!enf_only && !r.blk);
                    end
                end
                default: ;
            endcase
            pending.insert(pending.size(), r);
        endfunction

        function void check_result(filter_result_t got);
            filter_result_t want;
            results_seen++;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result %p", got);
                return;
            end
            want = pending.pop_front();
            if (got !== want) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Mismatch: expected %p, got %p", want, got);
            end
        endfunction
    endclass

    logic clk, rst_n;
    logic cfg_valid, cfg_data, in_valid, out_ready, mask_kind;
    logic cfg_ready, in_ready, out_valid;
    logic [OP_W-1:0] opcode;
    logic [OBJ_W-1:0] object_number;
    coord_t coord_x, coord_y, coord_z;
    logic [STAT_W-1:0] status;
    logic keep_point, layer_found, inside_enforcer, inside_blocker;

    support_point_mask_filter_top uut (.*);

    mask_filter_scoreboard board;
    int cycles;
    int sender_idle_pct;
    int sink_idle_pct;
    int sink_hold;
    int queries_sent;

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > 3000000) begin
            $display("Timeout after %0d cycles", cycles);
            $display("** support_point_mask_filter_top: FAILED **");
            $finish;
        end
    end

    // Result side: random stalls plus an optional long hold-off.
    always @(posedge clk) begin
        if (rst_n) begin
            if (out_valid && out_ready)
                board.check_result({status, keep_point, layer_found,
                                    inside_enforcer, inside_blocker});
            if (sink_hold > 0) begin
                sink_hold <= sink_hold - 1;
                out_ready <= 0;
            end else
                out_ready <= ($urandom_range(99) >= sink_idle_pct);
        end
    end

    // Valid stays high after an accepted item until the next item or an idle
    // cycle replaces it; the block is busy in the meantime.
    task automatic send_item(logic [2:0] op, logic [7:0] obj, coord_t x, coord_t y,
                             coord_t z, bit kind);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 0;
            @(posedge clk);
        end
        in_valid <= 1;
        opcode <= op; object_number <= obj;
        coord_x <= x; coord_y <= y; coord_z <= z; mask_kind <= kind;
        do @(posedge clk); while (!in_ready);
        board.note_item(op, obj, x, y, z, kind);
        if (op == OP_QUERY) queries_sent++;
    endtask

    task automatic drain();
        in_valid <= 0;
        while (board.pending.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_mode(bit val);
        drain();
        cfg_valid <= 1;
        cfg_data <= val;
        do @(posedge clk); while (!cfg_ready);
        board.enf_only = val;
        cfg_valid <= 0;
    endtask

    function automatic coord_t small_coord();
        return coord_t'($signed($urandom_range(40)) - 20) <<< 16;
    endfunction

    // Random content on a small grid so polygons actually cover query points.
    task automatic random_scene(int n_layers);
        int nv;
        send_item(OP_CLEAR, 0, 0, 0, 0, 0);
        for (int l = 0; l < n_layers; l++) begin
            send_item(OP_LAYER, 8'($urandom_range(3)), 0, 0, small_coord(), 0);
            repeat ($urandom_range(3)) begin
                send_item(OP_POLYGON, 0, 0, 0, 0, 1'($urandom_range(1)));
                nv = $urandom_range(6);
                repeat (nv) send_item(OP_VERTEX, 0, small_coord(), small_coord(), 0, 0);
            end
        end
        repeat ($urandom_range(12, 4))
            send_item(OP_QUERY, 8'($urandom_range(3)),
                      small_coord() + $urandom_range(3) * 16384,
                      small_coord(), small_coord(), 0);
        if ($urandom_range(9) == 0)
            send_item(3'($urandom_range(7)), 8'($urandom), $urandom, $urandom, $urandom,
                      1'($urandom));
    endtask

    initial begin
        board = new();
        cycles = 0; sink_hold = 0; queries_sent = 0;
        sender_idle_pct = 0; sink_idle_pct = 0;
        rst_n = 0; cfg_valid = 0; cfg_data = 0; in_valid = 0; out_ready = 0;
        opcode = '0; object_number = '0; coord_x = '0; coord_y = '0; coord_z = '0;
        mask_kind = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // Directed: empty tables, open errors, unused opcodes, extremes.
        send_item(OP_QUERY, 8'hFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 0);
        send_item(OP_POLYGON, 0, 0, 0, 0, 1);
        send_item(OP_LAYER, 8'hFF, 0, 0, 32'h7FFFFFFF, 0);
        send_item(OP_VERTEX, 0, 32'h7FFFFFFF, 32'h7FFFFFFF, 0, 0);
        send_item(OP_POLYGON, 0, 0, 0, 0, 0);
        send_item(OP_QUERY, 8'hFF, 0, 0, 32'h80000000, 0);
        send_item(OP_VERTEX, 0, 32'h80000000, 32'h80000000, 0, 0);
        send_item(OP_VERTEX, 0, 32'h7FFFFFFF, 32'h80000000, 0, 0);
        send_item(OP_VERTEX, 0, 32'h80000000, 32'h7FFFFFFF, 0, 0);
        send_item(OP_QUERY, 8'hFF, 32'h80000001, 32'h80000001, 32'h7FFFFFFF, 0);
        send_item(OP_QUERY, 8'hFF, 0, 0, 0, 0);
        send_item(OP_POLYGON, 0, 0, 0, 0, 1);
        send_item(OP_VERTEX, 0, 0, 0, 0, 0);
        send_item(OP_QUERY, 8'hFF, 0, 0, 0, 0);
        send_item(5, 8'hAA, 32'h55555555, 32'hAAAAAAAA, 32'h12345678, 1);
        send_item(6, 0, 0, 0, 0, 0);
        send_item(7, 0, 0, 0, 0, 0);
        send_item(OP_QUERY, 8'h00, 0, 0, 0, 0);
        write_mode(1);
        send_item(OP_QUERY, 8'hFF, 0, 0, 0, 0);
        send_item(OP_CLEAR, 0, 0, 0, 0, 0);
        send_item(OP_VERTEX, 0, 0, 0, 0, 0);
        send_item(OP_QUERY, 8'hFF, 0, 0, 0, 0);

        // Fill the layer and polygon tables past their limits.
        for (int i = 0; i <= MAX_LAYERS; i++)
            send_item(OP_LAYER, i[7:0], 0, 0, i <<< 16, 0);
        for (int i = 0; i <= MAX_POLYGONS; i++) send_item(OP_POLYGON, 0, 0, 0, 0, i[0]);
        send_item(OP_VERTEX, 0, $urandom, $urandom, 0, 0);
        send_item(OP_QUERY, 8'd63, 0, 0, 0, 0);
        write_mode(0);

        // Random scenes with idling; one stretch without any.
        sender_idle_pct = 19; sink_idle_pct = 19;
        for (int s = 0; s < 20; s++) begin
            if (s == 7) begin sender_idle_pct = 0; sink_idle_pct = 0; end
            if (s == 10) begin sender_idle_pct = 19; sink_idle_pct = 19; end
            if (s == 13) sink_hold = 400;
            if (s % 5 == 4) write_mode(1'($urandom_range(1)));
            random_scene($urandom_range(5, 1));
            if (s == 15) drain();
        end

        drain();
        $display("Checked %0d results, including %0d point queries, under both filter modes.",
                 board.results_seen, queries_sent);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("** support_point_mask_filter_top: PASSED **");
        else
            $display("** support_point_mask_filter_top: FAILED **");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/spmf_pkg.sv
rtl/spmf_ram.sv
rtl/spmf_cross.sv
rtl/support_point_mask_filter_top.sv
tb/sv/support_point_mask_filter_top_tb.sv
